// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the allocator RTL.
// No dependencies; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PCPFL_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define PCPFL_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pcpfl_pkg.sv -----
// Package for the per-CPU page free list allocator: sizes, codes and types.
// No dependencies; imported by pcpfl_alu, pcpfl_heads and the top level.
`default_nettype none

package pcpfl_pkg;

  localparam int CPU_COUNT  = 8;
  localparam int POOL_PAGES = 32768;
  localparam int PAGE_BYTES = 4096;

  localparam int ADDR_W    = 40;
  localparam int CPU_W     = 3;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CPU_IDX_W = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int PAGE_W    = $clog2(POOL_PAGES);
  localparam int OFFS_W    = $clog2(PAGE_BYTES);
  localparam int ALU_W     = ADDR_W + 2;
  localparam int LINK_W    = PAGE_W + 1;

  localparam logic [CPU_W:0]      CPU_LIM    = (CPU_W + 1)'(CPU_COUNT);
  localparam logic [ALU_W-1:0]    PAGE_M1    = ALU_W'(PAGE_BYTES - 1);
  localparam logic [ALU_W-1:0]    POOL_LIM   = ALU_W'(POOL_PAGES);
  localparam logic [ADDR_W-1:0]   LOWER_RST  = 40'h00_8000_0000;
  localparam logic [ADDR_W-1:0]   UPPER_RST  = 40'h00_8800_0000;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOWER = 1'b0,
    CFG_UPPER = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic                 we;
    logic [CPU_IDX_W-1:0] idx;
    logic                 valid;
    logic [PAGE_W-1:0]    page;
  } head_wr_t;

  typedef struct packed {
    logic                 hit;
    logic [CPU_IDX_W-1:0] idx;
    logic [PAGE_W-1:0]    page;
  } head_rd_t;

endpackage

`default_nettype wire

// ----- rtl/pcpfl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the shared next-link store.
`default_nettype none

module pcpfl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/pcpfl_alu.sv -----
// Shared add/subtract unit used by the sequencer for every address step.
// Depends on pcpfl_pkg.
`default_nettype none

module pcpfl_alu (
  input  wire logic [pcpfl_pkg::ALU_W-1:0] a,
  input  wire logic [pcpfl_pkg::ALU_W-1:0] b,
  input  wire pcpfl_pkg::alu_op_t          op,
  output logic      [pcpfl_pkg::ALU_W-1:0] y
);
  import pcpfl_pkg::*;

  always_comb begin
    unique case (op)
      ALU_ADD: y = a + b;
      ALU_SUB: y = a - b;
      default: y = a + b;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/pcpfl_heads.sv -----
// Per-CPU list head registers with valid bits and the steal selection.
// Depends on pcpfl_pkg.
`default_nettype none

module pcpfl_heads (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [pcpfl_pkg::CPU_W-1:0] cpu,
  input  wire logic                        own_only,
  input  wire pcpfl_pkg::head_wr_t         hw,
  output pcpfl_pkg::head_rd_t              hr
);
  import pcpfl_pkg::*;

  logic [CPU_COUNT-1:0] head_v_r;
  logic [PAGE_W-1:0]    head_pg_r [CPU_COUNT];
  logic                 cpu_ok;
  logic                 own_ok;
  logic                 low_hit;
  logic [CPU_IDX_W-1:0] own_idx;
  logic [CPU_IDX_W-1:0] low_idx;
  logic [CPU_IDX_W-1:0] pick;

  always_comb begin
    own_idx = cpu[CPU_IDX_W-1:0];
    cpu_ok  = {1'b0, cpu} < CPU_LIM;
    own_ok  = cpu_ok && head_v_r[own_idx];
    low_hit = 1'b0;
    low_idx = '0;
    for (int i = CPU_COUNT - 1; i >= 0; i--) begin
      if (head_v_r[i] && (CPU_W'(i) != cpu)) begin
        low_hit = 1'b1;
        low_idx = CPU_IDX_W'(i);
      end
    end
    pick    = (own_only || own_ok) ? own_idx : low_idx;
    hr.idx  = pick;
    hr.page = head_pg_r[pick];
    hr.hit  = own_only ? head_v_r[own_idx] : (own_ok || low_hit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= '0;
    end else if (hw.we) begin
      head_v_r[hw.idx] <= hw.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hw.we) begin
      head_pg_r[hw.idx] <= hw.page;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/per_cpu_page_free_list_allocator.sv -----
// Top level of the per-CPU page free list allocator: sequencer and result register.
// Depends on pcpfl_pkg, pcpfl_alu, pcpfl_heads, pcpfl_ram and assert_macros.svh.
//
//   channel   handshake              payload
//   request   start / busy           in_action, in_cpu, in_page_address
//   result    out_valid (1 cycle)    out_granted_address, out_status, out_served_by
//   config    cfg_we                 cfg_index, cfg_wdata
//
// A request takes two or three steps: pool base in the shared 42-bit adder, then the upper
// check and the base check with push (free), or head select, address add and link read,
// then pop (allocate). A free failing alignment or the upper limit and an allocate with
// every list empty end after two steps; the result strobes the cycle after the last step.
// A new request is taken only in idle, once busy has fallen. Synchronous reset empties
// all lists and restores the limits; no clearing pass. The receiver cannot stall.
`default_nettype none

module per_cpu_page_free_list_allocator (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                in_action,
  input  wire logic [pcpfl_pkg::CPU_W-1:0]         in_cpu,
  input  wire logic [pcpfl_pkg::ADDR_W-1:0]        in_page_address,
  output logic                                     out_valid,
  output logic      [pcpfl_pkg::ADDR_W-1:0]        out_granted_address,
  output logic      [pcpfl_pkg::STATUS_W-1:0]      out_status,
  output logic      [pcpfl_pkg::CPU_W-1:0]         out_served_by,
  input  wire logic                                cfg_we,
  input  wire logic [pcpfl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pcpfl_pkg::ADDR_W-1:0]        cfg_wdata
);
  import pcpfl_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_BASE     = 6'b000010,
    S_CHK_UP   = 6'b000100,
    S_CHK_BASE = 6'b001000,
    S_ALLOC    = 6'b010000,
    S_POP      = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic                 act_r;
  logic [CPU_W-1:0]     cpu_r;
  logic [ADDR_W-1:0]    pa_r;
  logic [ADDR_W:0]      base_r;
  logic [ADDR_W-1:0]    lower_r;
  logic [ADDR_W-1:0]    upper_r;
  logic [CPU_IDX_W-1:0] sel_r;
  logic [ADDR_W-1:0]    res_addr_r;
  status_t              res_status_r;
  logic [CPU_W-1:0]     res_from_r;
  logic                 out_valid_r;

  logic [ALU_W-1:0]     alu_a, alu_b, alu_y;
  alu_op_t              alu_op;
  logic                 neg, over, misalign, cpu_bad, fin, accept;
  logic [ALU_W-1:0]     diff_pg;
  head_wr_t             hw;
  head_rd_t             hr;
  logic                 link_we;
  logic [PAGE_W-1:0]    link_waddr;
  logic [LINK_W-1:0]    link_rd;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign neg       = alu_y[ALU_W-1];
  assign diff_pg   = alu_y >> OFFS_W;
  assign over      = diff_pg >= POOL_LIM;
  assign misalign  = |pa_r[OFFS_W-1:0];
  assign cpu_bad   = !({1'b0, cpu_r} < CPU_LIM);
  assign link_waddr = alu_y[OFFS_W +: PAGE_W];
  assign link_we   = (state_r == S_CHK_BASE) && !neg && !over;

  always_comb begin
    alu_a  = '0;
    alu_b  = '0;
    alu_op = ALU_ADD;
    unique case (state_r)
      S_BASE: begin
        alu_a = ALU_W'(lower_r);
        alu_b = PAGE_M1;
      end
      S_CHK_UP: begin
        alu_a  = ALU_W'(pa_r);
        alu_b  = ALU_W'(upper_r);
        alu_op = ALU_SUB;
      end
      S_CHK_BASE: begin
        alu_a  = ALU_W'(pa_r);
        alu_b  = ALU_W'(base_r);
        alu_op = ALU_SUB;
      end
      S_ALLOC: begin
        alu_a = ALU_W'(base_r);
        alu_b = ALU_W'({hr.page, {OFFS_W{1'b0}}});
      end
      S_IDLE, S_POP: begin
        alu_op = ALU_ADD;
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    fin       = 1'b0;
    hw        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_BASE;
        end
      end
      S_BASE: begin
        state_nxt = act_r ? S_CHK_UP : S_ALLOC;
      end
      S_CHK_UP: begin
        if (misalign || cpu_bad || !neg) begin
          state_nxt = S_IDLE;
          fin       = 1'b1;
        end else begin
          state_nxt = S_CHK_BASE;
        end
      end
      S_CHK_BASE: begin
        state_nxt = S_IDLE;
        fin       = 1'b1;
        hw.we     = link_we;
        hw.idx    = cpu_r[CPU_IDX_W-1:0];
        hw.valid  = 1'b1;
        hw.page   = link_waddr;
      end
      S_ALLOC: begin
        if (hr.hit) begin
          state_nxt = S_POP;
        end else begin
          state_nxt = S_IDLE;
          fin       = 1'b1;
        end
      end
      S_POP: begin
        state_nxt = S_IDLE;
        fin       = 1'b1;
        hw.we     = 1'b1;
        hw.idx    = sel_r;
        hw.valid  = link_rd[PAGE_W];
        hw.page   = link_rd[PAGE_W-1:0];
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      lower_r     <= LOWER_RST;
      upper_r     <= UPPER_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= fin;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_LOWER: lower_r <= cfg_wdata;
          CFG_UPPER: upper_r <= cfg_wdata;
          default:   lower_r <= lower_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_action;
      cpu_r <= in_cpu;
      pa_r  <= in_page_address;
    end
    case (state_r)
      S_BASE: begin
        base_r <= {alu_y[ADDR_W:OFFS_W], {OFFS_W{1'b0}}};
      end
      S_CHK_UP: begin
        res_addr_r   <= '0;
        res_status_r <= ST_REJECT;
        res_from_r   <= '0;
      end
      S_CHK_BASE: begin
        res_addr_r   <= '0;
        res_status_r <= (neg || over) ? ST_REJECT : ST_DONE;
        res_from_r   <= '0;
      end
      S_ALLOC: begin
        sel_r <= hr.idx;
        if (hr.hit) begin
          res_addr_r   <= alu_y[ADDR_W-1:0];
          res_status_r <= ST_DONE;
          res_from_r   <= CPU_W'(hr.idx);
        end else begin
          res_addr_r   <= '0;
          res_status_r <= ST_EMPTY;
          res_from_r   <= '0;
        end
      end
      default: begin
        sel_r <= sel_r;
      end
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_granted_address = res_addr_r;
  assign out_status          = res_status_r;
  assign out_served_by       = res_from_r;

  pcpfl_alu u_alu (
    .a  (alu_a),
    .b  (alu_b),
    .op (alu_op),
    .y  (alu_y)
  );

  pcpfl_heads u_heads (
    .clk      (clk),
    .rst_n    (rst_n),
    .cpu      (cpu_r),
    .own_only (act_r),
    .hw       (hw),
    .hr       (hr)
  );

  pcpfl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (POOL_PAGES)
  ) u_links (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata ({hr.hit, hr.page}),
    .raddr (hr.page),
    .rdata (link_rd)
  );

  `PCPFL_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy, "accepted request not started")
  `PCPFL_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_valid, !out_valid, "result strobe held")
  `PCPFL_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_valid, !busy, "result shown while busy")
  `PCPFL_ASSERT_IMP(a_busy_cause, clk, rst_n, $rose(busy), $past(start), "busy without request")

endmodule

`default_nettype wire
